>>> rtl/nfa_pkg.sv
// Package for the next-fit free-list allocator.
// Holds request and response types, header layout, sizing constants and the
// controller state and datapath command encodings. Depends on nothing.
package nfa_pkg;

	localparam int ADDR_W      = 12;
	localparam int SIZE_W      = 13;
	localparam int BYTES_W     = 16;
	localparam int HEAP_UNITS  = 4096;
	localparam int GROW_UNITS  = 1024;
	localparam int UNIT_BYTES  = 16;
	localparam int SPLIT_MIN   = 2;
	localparam int WALK_LIMIT  = HEAP_UNITS + 2;
	localparam int ALLOC_LIMIT = 4 * HEAP_UNITS + 16;
	localparam int WSTEP_W     = $clog2(WALK_LIMIT + 1);
	localparam int ASTEP_W     = $clog2(ALLOC_LIMIT + 1);

	localparam logic OPC_ALLOC = 1'b0;
	localparam logic OPC_FREE  = 1'b1;
	localparam logic ST_OK     = 1'b0;
	localparam logic ST_OOM    = 1'b1;

	typedef struct packed {
		logic                op;
		logic [BYTES_W-1:0]  alloc_bytes;
		logic [ADDR_W-1:0]   block_address;
	} req_t;

	typedef struct packed {
		logic [ADDR_W-1:0] data_address;
		logic              status;
	} rsp_t;

	typedef struct packed {
		logic [ADDR_W-1:0] next;
		logic [SIZE_W-1:0] size;
	} hdr_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FREE,
		S_FREE_BH,
		S_INS_WALK,
		S_INS_N,
		S_INS_P,
		S_AL_START,
		S_AL_PREV,
		S_AL_CHK,
		S_AL_GROW,
		S_AL_POST,
		S_AL_SPLIT,
		S_RESP
	} state_t;

	typedef enum logic [3:0] {
		DP_NONE,
		DP_LOAD,
		DP_RD_BH,
		DP_FREE_START,
		DP_GROW_START,
		DP_WALK,
		DP_INS_N,
		DP_INS_P,
		DP_RD_ROVER,
		DP_AL_PREV,
		DP_AL_CHK,
		DP_AL_STEP,
		DP_SPLIT,
		DP_FAIL
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic op_free;
		logic free_ok;
		logic walk_hit;
		logic walk_over;
		logic fit;
		logic whole;
		logic at_rover;
		logic alloc_over;
		logic grow_ok;
	} dp_status_t;

endpackage

>>> rtl/nfa_ctrl.sv
// Controller state machine of the allocator.
// Sequences header reads and writes for allocate, free and break growth.
// Depends on nfa_pkg.
module nfa_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic               req_op,
	input  logic               out_free,
	input  nfa_pkg::dp_status_t st,
	output nfa_pkg::dp_cmd_t   cmd,
	output logic               busy,
	output logic               rsp_load
);
	import nfa_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd.op   = DP_NONE;
		rsp_load = 1'b0;
		busy     = (state_q != S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.op  = DP_LOAD;
					state_d = (req_op == OPC_FREE) ? S_FREE : S_AL_START;
				end
			end
			S_FREE: begin
				if (st.free_ok) begin
					cmd.op  = DP_RD_BH;
					state_d = S_FREE_BH;
				end else begin
					state_d = S_RESP;
				end
			end
			S_FREE_BH: begin
				cmd.op  = DP_FREE_START;
				state_d = S_INS_WALK;
			end
			S_INS_WALK: begin
				cmd.op = DP_WALK;
				if (st.walk_hit) begin
					state_d = S_INS_N;
				end else if (st.walk_over) begin
					// An overlong walk leaves the list as it was.
					state_d = st.op_free ? S_RESP : S_AL_POST;
				end
			end
			S_INS_N: begin
				cmd.op  = DP_INS_N;
				state_d = S_INS_P;
			end
			S_INS_P: begin
				cmd.op  = DP_INS_P;
				state_d = st.op_free ? S_RESP : S_AL_POST;
			end
			S_AL_START: begin
				cmd.op  = DP_RD_ROVER;
				state_d = S_AL_PREV;
			end
			S_AL_PREV: begin
				cmd.op  = DP_AL_PREV;
				state_d = S_AL_CHK;
			end
			S_AL_CHK: begin
				cmd.op = DP_AL_CHK;
				if (st.fit) begin
					state_d = st.whole ? S_RESP : S_AL_SPLIT;
				end else if (st.at_rover) begin
					state_d = S_AL_GROW;
				end else if (st.alloc_over) begin
					state_d = S_RESP;
				end
			end
			S_AL_GROW: begin
				if (st.grow_ok) begin
					cmd.op  = DP_GROW_START;
					state_d = S_INS_WALK;
				end else begin
					cmd.op  = DP_FAIL;
					state_d = S_RESP;
				end
			end
			S_AL_POST: begin
				cmd.op  = DP_AL_STEP;
				state_d = st.alloc_over ? S_RESP : S_AL_PREV;
			end
			S_AL_SPLIT: begin
				cmd.op  = DP_SPLIT;
				state_d = S_RESP;
			end
			S_RESP: begin
				if (out_free) begin
					rsp_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	a_resp_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESP && out_free) |=> (state_q == S_IDLE))
		else $error("response slot was free but the controller did not finish");

	a_split_resp: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_AL_SPLIT) |=> (state_q == S_RESP))
		else $error("split did not end the request");

	a_ins_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INS_N) |=> (state_q == S_INS_P))
		else $error("insert did not write the predecessor header");

endmodule

>>> rtl/nfa_datapath.sv
// Datapath of the allocator: header store, sentinel link, rover, break
// pointer and the working registers of the list walks.
// Depends on nfa_pkg.
module nfa_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  nfa_pkg::dp_cmd_t    cmd,
	input  nfa_pkg::req_t       req,
	output nfa_pkg::dp_status_t st,
	output nfa_pkg::rsp_t       res
);
	import nfa_pkg::*;

	hdr_t mem [HEAP_UNITS];
	hdr_t mem_q;
	logic rd_zero_q;

	logic [ADDR_W-1:0]  sentinel_next_q, rover_q;
	logic [SIZE_W-1:0]  brk_q;
	logic               op_q, addr_zero_q;
	logic [SIZE_W-1:0]  need_q, bh_size_q, p_size_q, prev_size_q, newbh_size_q;
	logic [ADDR_W-1:0]  bh_q, p_q, p_next_q, prev_q, newbh_next_q;
	logic [SIZE_W:0]    p2_q;
	logic [WSTEP_W-1:0] wsteps_q;
	logic [ASTEP_W-1:0] asteps_q;
	logic [ADDR_W-1:0]  res_addr_q;
	logic               res_status_q;

	hdr_t               rdata, wr_data;
	logic               wr_en;
	logic [ADDR_W-1:0]  wr_addr, rd_addr;
	logic [ADDR_W-1:0]  n_w;
	logic [SIZE_W-1:0]  rem, grow, newbh_size;
	logic [ADDR_W-1:0]  newbh_next;
	logic [SIZE_W:0]    p2;
	logic               merge1, merge2;
	logic [BYTES_W:0]   bytes_up;

	assign rdata = rd_zero_q ? hdr_t'{next: sentinel_next_q, size: '0} : mem_q;
	assign n_w   = rdata.next;
	assign rem   = rdata.size - need_q;
	assign p2    = {2'b0, p_q} + {1'b0, rem};
	assign grow  = (need_q > SIZE_W'(GROW_UNITS)) ? need_q : SIZE_W'(GROW_UNITS);
	assign bytes_up = ({1'b0, req.alloc_bytes} + (BYTES_W+1)'(UNIT_BYTES - 1))
		>> $clog2(UNIT_BYTES);

	assign merge1 = ({2'b0, bh_q} + {1'b0, bh_size_q}) == {2'b0, p_next_q};
	assign merge2 = ({2'b0, p_q} + {1'b0, p_size_q}) == {2'b0, bh_q};
	assign newbh_size = merge1 ? (bh_size_q + rdata.size) : bh_size_q;
	assign newbh_next = merge1 ? rdata.next : p_next_q;

	assign st.op_free    = (op_q == OPC_FREE);
	assign st.free_ok    = !addr_zero_q && ({1'b0, bh_q} < brk_q);
	assign st.walk_hit   = ((bh_q > p_q) && (bh_q < n_w)) ||
		((p_q >= n_w) && ((bh_q > p_q) || (bh_q < n_w)));
	assign st.walk_over  = (wsteps_q >= WSTEP_W'(WALK_LIMIT));
	assign st.fit        = (rdata.size >= need_q);
	assign st.whole      = (rem < SIZE_W'(SPLIT_MIN));
	assign st.at_rover   = (p_q == rover_q);
	assign st.alloc_over = (asteps_q >= ASTEP_W'(ALLOC_LIMIT));
	assign st.grow_ok    = ({1'b0, brk_q} + {1'b0, grow}) <= (SIZE_W+1)'(HEAP_UNITS);

	assign res.data_address = res_addr_q;
	assign res.status       = res_status_q;

	always_comb begin
		rd_addr = p_q;
		wr_en   = 1'b0;
		wr_addr = p_q;
		wr_data = '{next: rdata.next, size: rem};
		case (cmd.op)
			DP_RD_BH:      rd_addr = bh_q;
			DP_FREE_START: rd_addr = rover_q;
			DP_GROW_START: rd_addr = rover_q;
			DP_WALK:       rd_addr = n_w;
			DP_RD_ROVER:   rd_addr = rover_q;
			DP_AL_STEP:    rd_addr = rover_q;
			DP_AL_PREV:    rd_addr = rdata.next;
			DP_AL_CHK: begin
				rd_addr = st.fit ? p2[ADDR_W-1:0] : rdata.next;
				if (st.fit) begin
					wr_en = 1'b1;
					if (st.whole) begin
						wr_addr = prev_q;
						wr_data = '{next: rdata.next, size: prev_size_q};
					end
				end
			end
			DP_INS_N: begin
				wr_en   = 1'b1;
				wr_addr = bh_q;
				wr_data = '{next: newbh_next, size: newbh_size};
			end
			DP_INS_P: begin
				wr_en   = 1'b1;
				wr_addr = p_q;
				if (merge2) begin
					wr_data = '{next: newbh_next_q, size: p_size_q + newbh_size_q};
				end else begin
					wr_data = '{next: bh_q, size: p_size_q};
				end
			end
			DP_SPLIT: begin
				// The tail header may land beyond the store; that write is dropped.
				wr_en   = (p2_q < (SIZE_W+1)'(HEAP_UNITS));
				wr_addr = p2_q[ADDR_W-1:0];
				wr_data = '{next: rdata.next, size: need_q};
			end
			default: begin
				rd_addr = p_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		mem_q     <= mem[rd_addr];
		rd_zero_q <= (rd_addr == '0);
		if (wr_en && wr_addr != '0) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sentinel_next_q <= '0;
			rover_q         <= '0;
			brk_q           <= SIZE_W'(1);
		end else begin
			if (wr_en && wr_addr == '0) begin
				sentinel_next_q <= wr_data.next;
			end
			if (cmd.op == DP_GROW_START) begin
				brk_q <= brk_q + grow;
			end
			if (cmd.op == DP_INS_P) begin
				rover_q <= p_q;
			end
			if (cmd.op == DP_AL_CHK && st.fit) begin
				rover_q <= prev_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			DP_LOAD: begin
				op_q         <= req.op;
				need_q       <= bytes_up[SIZE_W-1:0] + SIZE_W'(1);
				bh_q         <= req.block_address - ADDR_W'(1);
				addr_zero_q  <= (req.block_address == '0);
				res_addr_q   <= '0;
				res_status_q <= ST_OK;
				asteps_q     <= '0;
			end
			DP_FREE_START: begin
				bh_size_q <= rdata.size;
				p_q       <= rover_q;
				wsteps_q  <= '0;
			end
			DP_GROW_START: begin
				bh_q      <= brk_q[ADDR_W-1:0];
				bh_size_q <= grow;
				p_q       <= rover_q;
				wsteps_q  <= '0;
			end
			DP_WALK: begin
				if (st.walk_hit) begin
					p_next_q <= n_w;
					p_size_q <= rdata.size;
				end else begin
					p_q      <= n_w;
					wsteps_q <= wsteps_q + WSTEP_W'(1);
				end
			end
			DP_INS_N: begin
				newbh_next_q <= newbh_next;
				newbh_size_q <= newbh_size;
			end
			DP_AL_STEP: begin
				asteps_q <= asteps_q + ASTEP_W'(1);
				if (st.alloc_over) begin
					res_status_q <= ST_OOM;
				end
			end
			DP_AL_PREV: begin
				prev_q      <= rover_q;
				prev_size_q <= rdata.size;
				p_q         <= rdata.next;
			end
			DP_AL_CHK: begin
				if (st.fit) begin
					if (st.whole) begin
						res_addr_q <= p_q + ADDR_W'(1);
					end else begin
						p2_q       <= p2;
						res_addr_q <= p2[ADDR_W-1:0] + ADDR_W'(1);
					end
				end else if (!st.at_rover) begin
					if (st.alloc_over) begin
						res_status_q <= ST_OOM;
					end else begin
						prev_q      <= p_q;
						prev_size_q <= rdata.size;
						p_q         <= rdata.next;
						asteps_q    <= asteps_q + ASTEP_W'(1);
					end
				end
			end
			DP_FAIL: begin
				res_addr_q   <= '0;
				res_status_q <= ST_OOM;
			end
			default: begin
				op_q <= op_q;
			end
		endcase
	end

endmodule

>>> rtl/next_fit_free_list_allocator_top.sv
// Next-fit free-list allocator: top level with the response register.
// A free walks the holes from the rover to its place (an invalid free is ignored); an allocate
// probes holes from the rover, splits a hole that is larger than needed, and grows the break
// with an insert walk each time it comes round to the rover without a fit.
// One request at a time; the next is accepted the cycle after the response is loaded.
// Reset (arst_n low) empties the list, puts the rover on the sentinel and the break at 1.
// Depends on nfa_pkg, nfa_ctrl and nfa_datapath.
module next_fit_free_list_allocator_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  nfa_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output nfa_pkg::rsp_t  rsp
);
	import nfa_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t st;
	rsp_t       res;
	rsp_t       rsp_q;
	logic       rsp_valid_q, rsp_load, busy, out_free;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = busy;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	nfa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_op   (req.op),
		.out_free (out_free),
		.st       (st),
		.cmd      (cmd),
		.busy     (busy),
		.rsp_load (rsp_load)
	);

	nfa_datapath u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.req   (req),
		.st    (st),
		.res   (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= res;
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_load |-> out_free)
		else $error("response overwritten while waiting");

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("controller took a request without going busy");

	a_oom_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status == ST_OOM) |-> (rsp.data_address == '0))
		else $error("failed allocate returned an address");

endmodule
